// ----- rtl/core/edc_pkg.sv -----
// Shared constants and types for the envelope dynamics compressor.
package edc_pkg;

   localparam int unsigned DATA_W     = 16;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned REG_IDX_W  = 2;

   localparam int unsigned DIV_STEPS  = 16;
   localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

   localparam logic [DATA_W-1:0] THRESHOLD_RST     = 16'd16384;
   localparam logic [DATA_W-1:0] INVERSE_RATIO_RST = 16'd16384;
   localparam logic [DATA_W-1:0] ATTACK_RST        = 16'd65000;
   localparam logic [DATA_W-1:0] RELEASE_RST       = 16'd65500;

   localparam logic [DATA_W-1:0] UNITY_GAIN = 16'h8000;
   localparam logic [DATA_W-1:0] POS_MAX    = 16'h7FFF;
   localparam logic [DATA_W-1:0] NEG_MAX    = 16'h8000;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_THRESHOLD     = 2'd0,
      REG_INVERSE_RATIO = 2'd1,
      REG_ATTACK        = 2'd2,
      REG_RELEASE       = 2'd3
   } reg_idx_type;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_ENV  = 5'b00010,
      ST_COMP = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_MAG  = 5'b10000
   } state_type;

endpackage

// ----- rtl/core/envelope_dynamics_compressor.sv -----
// Envelope follower with threshold compression of signed 16-bit audio beats.
//
// A sample passes through these steps from its accept to the next accept: capture, the
// envelope update (a single 17x18 multiply), the compressed level (16x16 multiply), the
// gain divide, which is a restoring divider retiring one quotient bit per cycle through a
// shift register, and the final scale and saturate into the output register. When the
// envelope is at or below the threshold the divide is skipped. The next sample is taken
// once the block is back in idle, even while the previous result still waits on
// rsp_tready; the final stage itself waits until the output register is free. The
// envelope clears after a beat with tlast set.
// Registers: threshold at 0x0, inverse ratio at 0x4, attack coefficient at 0x8, release
// coefficient at 0xC, 16 bits each; write them only while the block is idle.
module envelope_dynamics_compressor (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [edc_pkg::DATA_W-1:0]          req_tdata,   // [15:0] sample_in
   input  logic                                req_tlast,   // last_in_block
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [edc_pkg::DATA_W-1:0]          rsp_tdata,   // [15:0] sample_out
   output logic                                rsp_tlast,   // last_out
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [edc_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [edc_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [edc_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   localparam int unsigned W = edc_pkg::DATA_W;

   edc_pkg::state_type state_ff, state_in;

   logic [W-1:0] thr_ff, inv_ff, att_ff, rel_ff;
   logic [W-1:0] env_ff, env_in;
   logic [W-1:0] level_ff, level_in;
   logic         neg_ff, neg_in;
   logic         last_ff, last_in;
   logic [W-1:0] rem_ff, rem_in;
   logic [W-1:0] quot_ff, quot_in;
   logic [edc_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic         out_valid_ff, out_valid_in;
   logic [W-1:0] out_data_ff, out_data_in;
   logic         out_last_ff, out_last_in;

   logic                    csr_wr;
   edc_pkg::reg_idx_type    csr_idx;
   logic                    req_fire;
   logic [W-1:0]            coef;
   logic signed [W+1:0]     env_diff;
   logic signed [2*W+2:0]   env_prod;
   logic signed [W+2:0]     env_sum;
   logic [W-1:0]            excess;
   logic [2*W-1:0]          comp_prod;
   logic [W:0]              comp;
   logic [W+1:0]            trial;
   logic                    qbit;
   logic [2*W-1:0]          mag_prod;
   logic [W:0]              mag;
   logic [W-1:0]            sat;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = edc_pkg::reg_idx_type'(csr_paddr[edc_pkg::CSR_ADDR_W-1:2]);

   always_comb begin
      unique case (csr_idx)
         edc_pkg::REG_THRESHOLD:     csr_prdata = {16'b0, thr_ff};
         edc_pkg::REG_INVERSE_RATIO: csr_prdata = {16'b0, inv_ff};
         edc_pkg::REG_ATTACK:        csr_prdata = {16'b0, att_ff};
         edc_pkg::REG_RELEASE:       csr_prdata = {16'b0, rel_ff};
         default:                    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= edc_pkg::THRESHOLD_RST;
         inv_ff <= edc_pkg::INVERSE_RATIO_RST;
         att_ff <= edc_pkg::ATTACK_RST;
         rel_ff <= edc_pkg::RELEASE_RST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            edc_pkg::REG_THRESHOLD:     thr_ff <= csr_pwdata[W-1:0];
            edc_pkg::REG_INVERSE_RATIO: inv_ff <= csr_pwdata[W-1:0];
            edc_pkg::REG_ATTACK:        att_ff <= csr_pwdata[W-1:0];
            edc_pkg::REG_RELEASE:       rel_ff <= csr_pwdata[W-1:0];
            default: ;
         endcase
      end
   end

   assign req_tready = (state_ff == edc_pkg::ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

   // envelope' = level + floor(coef * (env - level) / 65536)
   assign coef     = (level_ff > env_ff) ? att_ff : rel_ff;
   assign env_diff = $signed({2'b0, env_ff}) - $signed({2'b0, level_ff});
   assign env_prod = $signed({1'b0, coef}) * env_diff;
   assign env_sum  = $signed({3'b0, level_ff}) + $signed(env_prod[2*W+2:W]);

   assign excess    = env_ff - thr_ff;
   assign comp_prod = excess * inv_ff;
   assign comp      = {1'b0, thr_ff} + comp_prod[2*W-1:W-1];

   // one restoring step of (comp << 15) / env
   assign trial = {1'b0, rem_ff, quot_ff[W-1]} - {2'b0, env_ff};
   assign qbit  = ~trial[W+1];

   assign mag_prod = level_ff * quot_ff;
   assign mag      = mag_prod[2*W-1:W-1];

   always_comb begin
      if (neg_ff) begin
         sat = (mag > {1'b0, edc_pkg::NEG_MAX}) ? edc_pkg::NEG_MAX : mag[W-1:0];
         sat = ~sat + W'(1);
      end else begin
         sat = (mag > {1'b0, edc_pkg::POS_MAX}) ? edc_pkg::POS_MAX : mag[W-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      env_in       = env_ff;
      level_in     = level_ff;
      neg_in       = neg_ff;
      last_in      = last_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff & ~rsp_tready;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;

      unique case (state_ff)
         edc_pkg::ST_IDLE: begin
            if (req_fire) begin
               neg_in   = req_tdata[W-1];
               level_in = req_tdata[W-1] ? (~req_tdata + W'(1)) : req_tdata;
               last_in  = req_tlast;
               state_in = edc_pkg::ST_ENV;
            end
         end
         edc_pkg::ST_ENV: begin
            env_in   = env_sum[W-1:0];
            state_in = edc_pkg::ST_COMP;
         end
         edc_pkg::ST_COMP: begin
            cnt_in = '0;
            if (env_ff > thr_ff) begin
               rem_in   = comp[W:1];
               quot_in  = {comp[0], {(W-1){1'b0}}};
               state_in = edc_pkg::ST_DIV;
            end else begin
               quot_in  = edc_pkg::UNITY_GAIN;
               state_in = edc_pkg::ST_MAG;
            end
         end
         edc_pkg::ST_DIV: begin
            rem_in  = qbit ? trial[W-1:0] : {rem_ff[W-2:0], quot_ff[W-1]};
            quot_in = {quot_ff[W-2:0], qbit};
            cnt_in  = cnt_ff + edc_pkg::DIV_CNT_W'(1);
            if (cnt_ff == edc_pkg::DIV_CNT_W'(edc_pkg::DIV_STEPS - 1)) begin
               state_in = edc_pkg::ST_MAG;
            end
         end
         edc_pkg::ST_MAG: begin
            if (!out_valid_ff || rsp_tready) begin
               out_valid_in = 1'b1;
               out_data_in  = sat;
               out_last_in  = last_ff;
               if (last_ff) begin
                  env_in = '0;
               end
               state_in = edc_pkg::ST_IDLE;
            end
         end
         default: state_in = edc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= edc_pkg::ST_IDLE;
         env_ff       <= '0;
         out_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         env_ff       <= env_in;
         out_valid_ff <= out_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff    <= level_in;
      neg_ff      <= neg_in;
      last_ff     <= last_in;
      rem_ff      <= rem_in;
      quot_ff     <= quot_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

endmodule

// ----- rtl/core/edc_checker.sv -----
// Port-level checks for the envelope dynamics compressor and their bind.
module edc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [edc_pkg::DATA_W-1:0]     rsp_tdata,
   input logic                           rsp_tlast,
   input logic                           csr_pready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp beat changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req taken while a sample is in flight");

   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("rsp beat appeared right after capture");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not idle after reset");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("csr_pready dropped");

endmodule

bind envelope_dynamics_compressor edc_checker u_edc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .csr_pready (csr_pready)
);
